@@ rtl/sliding_peak_midpoint_baseline_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sliding peak midpoint baseline block
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_PEAK_MIDPOINT_BASELINE_TOP_ASSERT_SVH
`define SLIDING_PEAK_MIDPOINT_BASELINE_TOP_ASSERT_SVH

// Same-cycle implication.
`define SPMB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spmb assertion failed");

// Next-cycle implication.
`define SPMB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spmb assertion failed");

`endif

@@ rtl/spmb_pkg.sv @@
// ----------------------------------------------------------------------------
// spmb_pkg
// Widths, depth constants and the command and status records that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spmb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 3;
    localparam int RING_DEPTH = 5;
    localparam int SLOT_W     = $clog2(RING_DEPTH);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

    typedef struct packed {
        logic load;
        logic insert;
        logic scan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

@@ rtl/spmb_if.sv @@
// ----------------------------------------------------------------------------
// Sample and result channels
// Valid/ready channels for the incoming samples and the outgoing results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spmb_sample_if;
    logic                          valid;
    logic                          ready;
    logic [spmb_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface spmb_result_if;
    logic                          valid;
    logic                          ready;
    logic [spmb_pkg::SAMPLE_W-1:0] baseline;
    logic [spmb_pkg::SAMPLE_W-1:0] window_high;
    logic [spmb_pkg::SAMPLE_W-1:0] window_low;
    logic [spmb_pkg::COUNT_W-1:0]  held_count;

    modport source (output valid, output baseline, output window_high,
                    output window_low, output held_count, input ready);
    modport sink   (input valid, input baseline, input window_high,
                    input window_low, input held_count, output ready);
endinterface

@@ rtl/spmb_ctrl.sv @@
// ----------------------------------------------------------------------------
// spmb_ctrl
// Sequencer: takes a sample, inserts it, walks the older entries, then hands
// the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_peak_midpoint_baseline_top_assert.svh"

module spmb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  spmb_pkg::t_status i_status,
    output spmb_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_INSERT = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_INSERT;
                end
            end
            ST_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // A finished result waits here only while the previous one is
                // still unclaimed at the output.
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SPMB_ASSERT_NEXT(a_accept_goes_insert, o_cmd.load, r_state == ST_INSERT)
    `SPMB_ASSERT_NOW(a_emit_needs_room, o_cmd.emit, i_status.out_free)
    `SPMB_ASSERT_NOW(a_ready_only_in_idle, o_in_ready, r_state == ST_IDLE)

endmodule

@@ rtl/spmb_dp.sv @@
// ----------------------------------------------------------------------------
// spmb_dp
// Sample ring, window pointers, min/max scan and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_peak_midpoint_baseline_top_assert.svh"

module spmb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spmb_pkg::t_cmd                i_cmd,
    output spmb_pkg::t_status             o_status,
    input  logic [spmb_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [spmb_pkg::SAMPLE_W-1:0] o_baseline,
    output logic [spmb_pkg::SAMPLE_W-1:0] o_window_high,
    output logic [spmb_pkg::SAMPLE_W-1:0] o_window_low,
    output logic [spmb_pkg::COUNT_W-1:0]  o_held_count
);

    function automatic logic [spmb_pkg::SLOT_W-1:0] wrap_add(
        input logic [spmb_pkg::SLOT_W-1:0] a,
        input logic [spmb_pkg::SLOT_W-1:0] b
    );
        logic [spmb_pkg::SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (spmb_pkg::SLOT_W + 1)'(spmb_pkg::RING_DEPTH)) begin
            sum = sum - (spmb_pkg::SLOT_W + 1)'(spmb_pkg::RING_DEPTH);
        end
        return sum[spmb_pkg::SLOT_W-1:0];
    endfunction

    logic [spmb_pkg::SAMPLE_W-1:0] r_ring [spmb_pkg::RING_DEPTH];
    logic [spmb_pkg::SAMPLE_W-1:0] r_sample;
    logic [spmb_pkg::SAMPLE_W-1:0] r_high;
    logic [spmb_pkg::SAMPLE_W-1:0] r_low;
    logic [spmb_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                          r_rd_vld;
    logic [spmb_pkg::SLOT_W-1:0]   r_oldest;
    logic [spmb_pkg::SLOT_W-1:0]   r_fill;
    logic [spmb_pkg::SLOT_W-1:0]   r_scan;
    logic                          r_out_vld;
    logic [spmb_pkg::SAMPLE_W-1:0] r_out_base;
    logic [spmb_pkg::SAMPLE_W-1:0] r_out_high;
    logic [spmb_pkg::SAMPLE_W-1:0] r_out_low;
    logic [spmb_pkg::COUNT_W-1:0]  r_out_count;

    logic [spmb_pkg::SLOT_W-1:0]   wr_slot;
    logic [spmb_pkg::SLOT_W-1:0]   rd_addr;
    logic [spmb_pkg::SLOT_W-1:0]   older_cnt;
    logic                          ring_full;
    logic                          issue;
    logic [spmb_pkg::SAMPLE_W:0]   mid_sum;

    assign wr_slot   = wrap_add(r_oldest, r_fill);
    assign ring_full = (r_fill == spmb_pkg::LAST_SLOT);
    // The newest sample seeds the scan, so only the entries before it are read.
    assign older_cnt = r_fill - spmb_pkg::SLOT_W'(1);
    assign rd_addr   = wrap_add(r_oldest, r_scan);
    assign issue     = i_cmd.scan && (r_scan != older_cnt);
    assign mid_sum   = {1'b0, r_high} + {1'b0, r_low};

    assign o_status.scan_done = (r_scan == older_cnt) && !r_rd_vld;
    assign o_status.out_free  = !r_out_vld || i_out_ready;

    // Ring storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_ring[wr_slot] <= r_sample;
        end
        if (issue) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.insert) begin
            r_high <= r_sample;
            r_low  <= r_sample;
        end else if (r_rd_vld) begin
            if (r_rd_data > r_high) begin
                r_high <= r_rd_data;
            end
            if (r_rd_data < r_low) begin
                r_low <= r_rd_data;
            end
        end
        if (i_cmd.emit) begin
            r_out_base  <= mid_sum[spmb_pkg::SAMPLE_W:1];
            r_out_high  <= r_high;
            r_out_low   <= r_low;
            r_out_count <= spmb_pkg::COUNT_W'(r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_fill    <= '0;
            r_scan    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                // Filling the last free slot drops the oldest sample at once.
                if (ring_full) begin
                    r_oldest <= wrap_add(r_oldest, spmb_pkg::SLOT_W'(1));
                end else begin
                    r_fill <= r_fill + spmb_pkg::SLOT_W'(1);
                end
                r_scan <= '0;
            end else if (issue) begin
                r_scan <= r_scan + spmb_pkg::SLOT_W'(1);
            end
            r_rd_vld <= issue;
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_baseline    = r_out_base;
    assign o_window_high = r_out_high;
    assign o_window_low  = r_out_low;
    assign o_held_count  = r_out_count;

    `SPMB_ASSERT_NOW(a_fill_in_range, 1'b1, r_fill <= spmb_pkg::LAST_SLOT)
    `SPMB_ASSERT_NOW(a_oldest_in_range, 1'b1, r_oldest <= spmb_pkg::LAST_SLOT)
    `SPMB_ASSERT_NEXT(a_emit_sets_valid, i_cmd.emit, r_out_vld && r_fill != '0)

endmodule

@@ rtl/sliding_peak_midpoint_baseline_top.sv @@
// ----------------------------------------------------------------------------
// sliding_peak_midpoint_baseline_top
// Sliding-window peak tracker that reports the window's high, low, held count
// and the floored midpoint of high and low as a baseline.
// ----------------------------------------------------------------------------
// Usage:
//   i_smp carries one 16-bit sample per request; o_res returns exactly one
//   result per sample: baseline, window_high, window_low and held_count.
//   The window keeps the newest RING_DEPTH-1 samples (four by default).
//   Steps: the block takes the sample, writes it into the ring, then walks
//   each older entry through the ring's registered read port and compares
//   it, drains the last compare and sees the scan end, and loads the output
//   register. No older entry is read when the new sample is the only one
//   held. One sample is in work at a time: a new one is taken only after the
//   result of the last has been loaded into the output register.
//   The output register separates the two sides: a new sample is taken while
//   an earlier result still waits, and only the load of the next result waits
//   for o_res.ready. A stalled receiver therefore holds at most one result
//   plus one finished scan inside the block.
//   Reset empties the window at once; ring contents need no clearing because
//   only entries written since reset are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_peak_midpoint_baseline_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spmb_sample_if.sink   i_smp,
    spmb_result_if.source o_res
);

    spmb_pkg::t_cmd    cmd;
    spmb_pkg::t_status status;
    logic              in_ready;

    spmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    spmb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_sample      (i_smp.sample),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_baseline    (o_res.baseline),
        .o_window_high (o_res.window_high),
        .o_window_low  (o_res.window_low),
        .o_held_count  (o_res.held_count)
    );

    assign i_smp.ready = in_ready;

endmodule
